// ===== rtl/jprb_pkg.sv =====
// shared types, command codes and reply constants for the joypad poll response builder
// no dependencies; used by every file under rtl

package jprb_pkg;

   localparam int REPLY_MAX = 10;
   localparam int CNT_W     = $clog2(REPLY_MAX + 1);

   typedef logic [7:0] octet_type;
   typedef logic [11:0] sample_type;
   typedef logic [CNT_W-1:0] count_type;

   // first command byte
   localparam octet_type CMD_IDENT   = 8'h00;
   localparam octet_type CMD_POLL    = 8'h40;
   localparam octet_type CMD_ORIGINS = 8'h41;
   localparam octet_type CMD_CALIB   = 8'h42;
   localparam octet_type CMD_RESET   = 8'hFF;

   // poll packing modes (second command byte)
   localparam octet_type PM_0 = 8'd0;
   localparam octet_type PM_1 = 8'd1;
   localparam octet_type PM_2 = 8'd2;
   localparam octet_type PM_3 = 8'd3;
   localparam octet_type PM_4 = 8'd4;
   localparam octet_type PM_5 = 8'd5;
   localparam octet_type PM_6 = 8'd6;
   localparam octet_type PM_7 = 8'd7;

   localparam octet_type ID_B0         = 8'h09;
   localparam octet_type ID_B1         = 8'h00;
   localparam octet_type ID_B2         = 8'h03;
   localparam octet_type ORIGIN_CENTER = 8'h80;
   localparam octet_type OCTET_ZERO    = 8'h00;

   localparam count_type ID_LEN    = count_type'(3);
   localparam count_type POLL_LEN  = count_type'(8);
   localparam count_type CALIB_LEN = count_type'(REPLY_MAX);

   localparam logic [12:0] SAMPLE_FULL = 13'd4095;

   typedef struct packed {
      octet_type  command;
      octet_type  poll_mode;
      octet_type  buttons_first;
      octet_type  buttons_second;
      sample_type stick_x;
      sample_type stick_y;
      sample_type cstick_x;
      sample_type cstick_y;
      octet_type  right_trigger;
      octet_type  left_trigger;
   } req_type;

   // data[0] goes out first
   typedef struct packed {
      octet_type [REPLY_MAX-1:0] data;
      count_type                 count;
   } reply_type;

   // floor(s * 255 / 4095): t = s*255 = a*4096 + b = a*4095 + (a + b), a + b < 2*4095
   function automatic octet_type scale_sample(input sample_type s);
      logic [19:0] t;
      logic [12:0] sum;
      octet_type   a;
      t   = {s, 8'd0} - {8'd0, s};
      a   = t[19:12];
      sum = {5'd0, a} + {1'b0, t[11:0]};
      return a + {7'd0, (sum >= SAMPLE_FULL)};
   endfunction

   function automatic octet_type pack_nibbles(input octet_type hi_src, input octet_type lo_src);
      return {hi_src[7:4], lo_src[7:4]};
   endfunction

endpackage

// ===== rtl/jprb_if.sv =====
// valid/ready channel interfaces for the command side and the reply side
// depends on jprb_pkg

interface jprb_req_if;
   logic                   valid;
   logic                   ready;
   jprb_pkg::octet_type    command;
   jprb_pkg::octet_type    poll_mode;
   jprb_pkg::octet_type    buttons_first;
   jprb_pkg::octet_type    buttons_second;
   jprb_pkg::sample_type   stick_x;
   jprb_pkg::sample_type   stick_y;
   jprb_pkg::sample_type   cstick_x;
   jprb_pkg::sample_type   cstick_y;
   jprb_pkg::octet_type    right_trigger;
   jprb_pkg::octet_type    left_trigger;

   modport source (
      output valid, command, poll_mode, buttons_first, buttons_second,
             stick_x, stick_y, cstick_x, cstick_y, right_trigger, left_trigger,
      input  ready
   );
   modport sink (
      input  valid, command, poll_mode, buttons_first, buttons_second,
             stick_x, stick_y, cstick_x, cstick_y, right_trigger, left_trigger,
      output ready
   );
endinterface

interface jprb_rsp_if;
   logic                valid;
   logic                ready;
   jprb_pkg::octet_type reply_byte;
   logic                last_byte;

   modport source (output valid, reply_byte, last_byte, input ready);
   modport sink (input valid, reply_byte, last_byte, output ready);
endinterface

// ===== rtl/jprb_in_stage.sv =====
// input register: holds one accepted command transaction with its pad state
// depends on jprb_pkg and jprb_req_if

module jprb_in_stage (
   input  logic              clock,
   input  logic              reset,
   jprb_req_if.sink          req_chan,
   input  logic              take,
   output logic              vld,
   output jprb_pkg::req_type data
);

   logic              vld_ff;
   logic              vld_in;
   jprb_pkg::req_type data_ff;

   assign req_chan.ready = !vld_ff || take;
   assign vld_in         = req_chan.ready ? req_chan.valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         data_ff <= '{command:        req_chan.command,
                      poll_mode:      req_chan.poll_mode,
                      buttons_first:  req_chan.buttons_first,
                      buttons_second: req_chan.buttons_second,
                      stick_x:        req_chan.stick_x,
                      stick_y:        req_chan.stick_y,
                      cstick_x:       req_chan.cstick_x,
                      cstick_y:       req_chan.cstick_y,
                      right_trigger:  req_chan.right_trigger,
                      left_trigger:   req_chan.left_trigger};
      end
   end

   assign vld  = vld_ff;
   assign data = data_ff;

endmodule

// ===== rtl/jprb_builder.sv =====
// reply assembly: turns one registered command and pad state into the reply bytes and length
// depends on jprb_pkg

module jprb_builder (
   input  jprb_pkg::req_type   req_data,
   output jprb_pkg::reply_type reply
);

   always_comb begin
      jprb_pkg::octet_type sx;
      jprb_pkg::octet_type sy;
      jprb_pkg::octet_type cx;
      jprb_pkg::octet_type cy;
      jprb_pkg::octet_type rt;
      jprb_pkg::octet_type lt;

      sx = jprb_pkg::scale_sample(req_data.stick_x);
      sy = jprb_pkg::scale_sample(req_data.stick_y);
      cx = jprb_pkg::scale_sample(req_data.cstick_x);
      cy = jprb_pkg::scale_sample(req_data.cstick_y);
      rt = req_data.right_trigger;
      lt = req_data.left_trigger;

      reply = '0;

      unique case (req_data.command)
         jprb_pkg::CMD_IDENT, jprb_pkg::CMD_RESET: begin
            reply.data[0] = jprb_pkg::ID_B0;
            reply.data[1] = jprb_pkg::ID_B1;
            reply.data[2] = jprb_pkg::ID_B2;
            reply.count   = jprb_pkg::ID_LEN;
         end
         jprb_pkg::CMD_CALIB: begin
            reply.data[1] = jprb_pkg::ORIGIN_CENTER;
            reply.data[2] = jprb_pkg::ORIGIN_CENTER;
            reply.data[3] = jprb_pkg::ORIGIN_CENTER;
            reply.data[4] = jprb_pkg::ORIGIN_CENTER;
            reply.data[5] = jprb_pkg::ORIGIN_CENTER;
            reply.count   = jprb_pkg::CALIB_LEN;
         end
         jprb_pkg::CMD_POLL: begin
            reply.data[0] = req_data.buttons_first;
            reply.data[1] = req_data.buttons_second;
            reply.data[2] = sx;
            reply.data[3] = sy;
            reply.data[4] = cx;
            reply.data[5] = cy;
            reply.data[6] = rt;
            reply.data[7] = lt;
            reply.count   = jprb_pkg::POLL_LEN;
            unique case (req_data.poll_mode)
               jprb_pkg::PM_0, jprb_pkg::PM_5, jprb_pkg::PM_6, jprb_pkg::PM_7: begin
                  reply.data[6] = jprb_pkg::pack_nibbles(lt, rt);
                  reply.data[7] = jprb_pkg::OCTET_ZERO;
               end
               jprb_pkg::PM_1: begin
                  reply.data[4] = jprb_pkg::pack_nibbles(cx, cy);
                  reply.data[5] = lt;
                  reply.data[6] = rt;
                  reply.data[7] = jprb_pkg::OCTET_ZERO;
               end
               jprb_pkg::PM_2: begin
                  reply.data[4] = jprb_pkg::pack_nibbles(cx, cy);
                  reply.data[5] = jprb_pkg::pack_nibbles(lt, rt);
                  reply.data[6] = jprb_pkg::OCTET_ZERO;
                  reply.data[7] = jprb_pkg::OCTET_ZERO;
               end
               jprb_pkg::PM_3: begin
                  reply.data[6] = lt;
                  reply.data[7] = rt;
               end
               jprb_pkg::PM_4: begin
                  reply.data[6] = jprb_pkg::OCTET_ZERO;
                  reply.data[7] = jprb_pkg::OCTET_ZERO;
               end
               // undefined modes keep sticks and triggers unpacked
               default: begin
               end
            endcase
         end
         // origins and unknown commands get no reply
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/jprb_serializer.sv =====
// reply register: loads a whole reply and shifts it out one byte per transaction
// depends on jprb_pkg and jprb_rsp_if

module jprb_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  jprb_pkg::reply_type reply,
   output logic                take,
   jprb_rsp_if.source          rsp_chan
);

   jprb_pkg::octet_type [jprb_pkg::REPLY_MAX-1:0] data_ff;
   jprb_pkg::count_type                           rem_ff;
   jprb_pkg::count_type                           rem_in;
   logic                                          fire;
   logic                                          on_last;

   assign on_last = (rem_ff == jprb_pkg::count_type'(1));
   assign fire    = rsp_chan.valid && rsp_chan.ready;
   // load when empty or when the final byte leaves this cycle
   assign take    = load_valid && ((rem_ff == '0) || (fire && on_last));

   always_comb begin
      priority if (take) begin
         rem_in = reply.count;
      end else if (fire) begin
         rem_in = rem_ff - jprb_pkg::count_type'(1);
      end else begin
         rem_in = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      priority if (take) begin
         data_ff <= reply.data;
      end else if (fire) begin
         data_ff <= {jprb_pkg::OCTET_ZERO, data_ff[jprb_pkg::REPLY_MAX-1:1]};
      end
   end

   assign rsp_chan.valid      = (rem_ff != '0);
   assign rsp_chan.reply_byte = data_ff[0];
   assign rsp_chan.last_byte  = on_last;

endmodule

// ===== rtl/joypad_poll_response_builder_unit.sv =====
// top level of the joypad poll response builder
// depends on jprb_pkg, jprb_if, jprb_in_stage, jprb_builder, jprb_serializer
//
// usage:
//   req_chan takes one command transaction: the two command bytes and the current
//   pad state (buttons, four 12-bit stick samples, two trigger bytes).
//   rsp_chan gives the reply bytes in transmission order, last_byte high on the
//   final one: 3 bytes for identify/reset, 8 for poll, 10 for calibrate, and
//   nothing at all for origins or any unknown command.
//   with the reply register idle, an accepted command passes through the input
//   register, the reply assembly and the reply register, in that order, before
//   its first reply byte is valid.
//   the reply register shifts out one reply byte per cycle while the receiver is
//   ready, and replies follow each other back to back.
//   the input register takes the next command while a reply is still going out.
//   reset clears both valid flags; no reply is in flight afterwards.
//   when the receiver stalls, the current byte holds and, once the input
//   register is full, req_chan.ready stays low until the final byte of the
//   current reply is taken.

module joypad_poll_response_builder_unit (
   input logic        clock,
   input logic        reset,
   jprb_req_if.sink   req_chan,
   jprb_rsp_if.source rsp_chan
);

   logic                in_vld;
   logic                take;
   jprb_pkg::req_type   in_data;
   jprb_pkg::reply_type reply;

   jprb_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .vld      (in_vld),
      .data     (in_data)
   );

   jprb_builder u_builder (
      .req_data (in_data),
      .reply    (reply)
   );

   jprb_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_vld),
      .reply      (reply),
      .take       (take),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== rtl/jprb_checker.sv =====
// port-level checks for the joypad poll response builder, bound to the top level
// depends on jprb_pkg and joypad_poll_response_builder_unit

module jprb_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input jprb_pkg::octet_type rsp_reply_byte,
   input logic                rsp_last_byte
);

   // stalled reply byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reply_byte)
                                  && $stable(rsp_last_byte))
      else $error("reply byte changed while stalled");

   // reset leaves no reply in flight
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("reply valid right after reset");

   // command side only backs up behind a reply that cannot finish this cycle
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !(rsp_ready && rsp_last_byte))
      else $error("command side stalled without a blocked reply");

   // a reply is never cut off before its final byte
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_byte |=> rsp_valid)
      else $error("reply ended without a final byte");

endmodule

bind joypad_poll_response_builder_unit jprb_checker u_jprb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_reply_byte (rsp_chan.reply_byte),
   .rsp_last_byte  (rsp_chan.last_byte)
);

// ===== dv/tb_joypad_poll_response_builder_unit.sv =====
// testbench for joypad_poll_response_builder_unit: drives command transactions with pad state
// and checks every reply byte against an in-bench predictor held in a small scoreboard class
// depends on rtl/jprb_pkg.sv, rtl/jprb_if.sv and the rtl top level
`timescale 1ns / 100ps

module tb_joypad_poll_response_builder_unit;

   typedef struct {
      jprb_pkg::octet_type data;
      logic                last;
   } reply_beat_type;

   class reply_scoreboard;
      reply_beat_type expected_bytes[$];
      int             mismatch_count;

      function int pending();
         return expected_bytes.size();
      endfunction

      // floor(s * 255 / 4095)
      function jprb_pkg::octet_type stick_to_octet(jprb_pkg::sample_type s);
         int unsigned v;
         v = (32'(s) * 32'd255) / 32'd4095;
         return jprb_pkg::octet_type'(v);
      endfunction

      function jprb_pkg::octet_type join_nibbles(jprb_pkg::octet_type hi_src,
                                                 jprb_pkg::octet_type lo_src);
         return (hi_src & 8'hF0) | (lo_src >> 4);
      endfunction

      function void note_command(jprb_pkg::req_type c);
         jprb_pkg::octet_type r [jprb_pkg::REPLY_MAX];
         int                  n;
         reply_beat_type      beat;
         n = 0;
         case (c.command)
            jprb_pkg::CMD_IDENT, jprb_pkg::CMD_RESET: begin
               r[0] = 8'h09;
               r[1] = 8'h00;
               r[2] = 8'h03;
               n = 3;
            end
            jprb_pkg::CMD_CALIB: begin
               r[0] = 8'h00;
               for (int k = 1; k <= 5; k++) r[k] = 8'h80;
               for (int k = 6; k < jprb_pkg::REPLY_MAX; k++) r[k] = 8'h00;
               n = jprb_pkg::REPLY_MAX;
            end
            jprb_pkg::CMD_POLL: begin
               r[0] = c.buttons_first;
               r[1] = c.buttons_second;
               r[2] = stick_to_octet(c.stick_x);
               r[3] = stick_to_octet(c.stick_y);
               r[4] = stick_to_octet(c.cstick_x);
               r[5] = stick_to_octet(c.cstick_y);
               r[6] = c.right_trigger;
               r[7] = c.left_trigger;
               case (c.poll_mode)
                  jprb_pkg::PM_0, jprb_pkg::PM_5, jprb_pkg::PM_6, jprb_pkg::PM_7: begin
                     r[6] = join_nibbles(c.left_trigger, c.right_trigger);
                     r[7] = 8'h00;
                  end
                  jprb_pkg::PM_1: begin
                     r[4] = join_nibbles(r[4], r[5]);
                     r[5] = c.left_trigger;
                     r[6] = c.right_trigger;
                     r[7] = 8'h00;
                  end
                  jprb_pkg::PM_2: begin
                     r[4] = join_nibbles(r[4], r[5]);
                     r[5] = join_nibbles(c.left_trigger, c.right_trigger);
                     r[6] = 8'h00;
                     r[7] = 8'h00;
                  end
                  jprb_pkg::PM_3: begin
                     r[6] = c.left_trigger;
                     r[7] = c.right_trigger;
                  end
                  jprb_pkg::PM_4: begin
                     r[6] = 8'h00;
                     r[7] = 8'h00;
                  end
                  default: ; // undefined modes send the raw values
               endcase
               n = 8;
            end
            default: n = 0; // origins and unknown commands get no reply
         endcase
         for (int k = 0; k < n; k++) begin
            beat.data = r[k];
            beat.last = (k == n - 1);
            expected_bytes.push_back(beat);
         end
      endfunction

      function void check_reply_byte(jprb_pkg::octet_type data, logic last);
         reply_beat_type exp_beat;
         if (expected_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected reply byte %02h last %0b", data, last);
            return;
         end
         exp_beat = expected_bytes.pop_front();
         if (data !== exp_beat.data || last !== exp_beat.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("reply mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                        exp_beat.data, exp_beat.last, data, last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   tx_burst;

   jprb_req_if req_if ();
   jprb_rsp_if rsp_if ();

   reply_scoreboard sb = new();

   joypad_poll_response_builder_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // both monitors see pre-edge values since all drives are nonblocking
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         sb.note_command('{req_if.command, req_if.poll_mode, req_if.buttons_first,
                           req_if.buttons_second, req_if.stick_x, req_if.stick_y,
                           req_if.cstick_x, req_if.cstick_y, req_if.right_trigger,
                           req_if.left_trigger});
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_reply_byte(rsp_if.reply_byte, rsp_if.last_byte);
   end

   // receiver: runs of ready broken by stalls, mostly short, sometimes long
   initial begin
      int run_len;
      int stall_len;
      int r;
      rsp_if.ready = 1'b0;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 40) run_len = $urandom_range(1, 3);
         else if (r < 80) run_len = $urandom_range(4, 15);
         else run_len = $urandom_range(30, 150);
         r = $urandom_range(0, 99);
         if (r < 30) stall_len = 0;
         else if (r < 80) stall_len = $urandom_range(1, 3);
         else if (r < 95) stall_len = $urandom_range(4, 10);
         else stall_len = $urandom_range(20, 60);
         rsp_if.ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         if (stall_len > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (tx_burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic jprb_pkg::sample_type rand_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 16) return jprb_pkg::sample_type'(4095);
      return jprb_pkg::sample_type'($urandom_range(0, 4095));
   endfunction

   function automatic jprb_pkg::req_type poll_cmd(jprb_pkg::octet_type mode);
      jprb_pkg::req_type c;
      c.command        = jprb_pkg::CMD_POLL;
      c.poll_mode      = mode;
      c.buttons_first  = jprb_pkg::octet_type'($urandom_range(0, 255));
      c.buttons_second = jprb_pkg::octet_type'($urandom_range(0, 255));
      c.stick_x        = rand_sample();
      c.stick_y        = rand_sample();
      c.cstick_x       = rand_sample();
      c.cstick_y       = rand_sample();
      c.right_trigger  = jprb_pkg::octet_type'($urandom_range(0, 255));
      c.left_trigger   = jprb_pkg::octet_type'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic jprb_pkg::req_type random_cmd();
      jprb_pkg::req_type c;
      int                r;
      // well-formed poll modes most of the time, any byte otherwise
      if ($urandom_range(0, 99) < 70)
         c = poll_cmd(jprb_pkg::octet_type'($urandom_range(jprb_pkg::PM_0, jprb_pkg::PM_7)));
      else
         c = poll_cmd(jprb_pkg::octet_type'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      if (r < 55) c.command = jprb_pkg::CMD_POLL;
      else if (r < 65) c.command = jprb_pkg::CMD_IDENT;
      else if (r < 75) c.command = jprb_pkg::CMD_RESET;
      else if (r < 85) c.command = jprb_pkg::CMD_CALIB;
      else if (r < 90) c.command = jprb_pkg::CMD_ORIGINS;
      else c.command = jprb_pkg::octet_type'($urandom_range(0, 255));
      return c;
   endfunction

   task automatic send_cmd(input jprb_pkg::req_type c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.command        <= c.command;
      req_if.poll_mode      <= c.poll_mode;
      req_if.buttons_first  <= c.buttons_first;
      req_if.buttons_second <= c.buttons_second;
      req_if.stick_x        <= c.stick_x;
      req_if.stick_y        <= c.stick_y;
      req_if.cstick_x       <= c.cstick_x;
      req_if.cstick_y       <= c.cstick_y;
      req_if.right_trigger  <= c.right_trigger;
      req_if.left_trigger   <= c.left_trigger;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // hold the sender off until every reply byte has come back
   task automatic wait_replies_done(input int tail);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   initial begin
      jprb_pkg::req_type c;
      reset                 = 1'b1;
      tx_burst              = 1'b0;
      req_if.valid          = 1'b0;
      req_if.command        = '0;
      req_if.poll_mode      = '0;
      req_if.buttons_first  = '0;
      req_if.buttons_second = '0;
      req_if.stick_x        = '0;
      req_if.stick_y        = '0;
      req_if.cstick_x       = '0;
      req_if.cstick_y       = '0;
      req_if.right_trigger  = '0;
      req_if.left_trigger   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: every command, every mode, field extremes
      c = poll_cmd('1);
      c.command = jprb_pkg::CMD_IDENT; // poll_mode must be ignored here
      send_cmd(c);
      c.command = jprb_pkg::CMD_RESET;
      send_cmd(c);
      c.command = jprb_pkg::CMD_ORIGINS;
      send_cmd(c);
      c.command = jprb_pkg::CMD_CALIB;
      send_cmd(c);
      c.command = jprb_pkg::CMD_POLL - 8'd1;
      send_cmd(c);
      c.command = jprb_pkg::CMD_CALIB + 8'd1;
      send_cmd(c);
      c.command = jprb_pkg::CMD_RESET - 8'd1;
      send_cmd(c);
      for (int m = jprb_pkg::PM_0; m <= jprb_pkg::PM_7; m++)
         send_cmd(poll_cmd(jprb_pkg::octet_type'(m)));
      send_cmd(poll_cmd(jprb_pkg::PM_7 + 8'd1));
      c = '{jprb_pkg::CMD_POLL, '1, '1, '1, '1, '1, '1, '1, '1, '1};
      send_cmd(c);
      c.poll_mode = jprb_pkg::PM_2;
      send_cmd(c);
      c = '{jprb_pkg::CMD_POLL, jprb_pkg::PM_1, '0, '0, '0, '0, '0, '0, '0, '0};
      send_cmd(c);
      c = '{jprb_pkg::CMD_POLL, jprb_pkg::PM_3, 8'h5A, 8'hA5, 12'd1, 12'd4094, 12'd2048,
            12'd17, 8'h0F, 8'hF0};
      send_cmd(c);
      c.poll_mode = jprb_pkg::PM_1;
      send_cmd(c);
      wait_replies_done(4);

      for (int k = 0; k < 380; k++) begin
         tx_burst = (k >= 150 && k < 200);
         send_cmd(random_cmd());
         if (k == 100 || k == 260) wait_replies_done($urandom_range(0, 6));
      end
      tx_burst = 1'b0;

      wait_replies_done(20);
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/jprb_pkg.sv
rtl/jprb_if.sv
rtl/jprb_in_stage.sv
rtl/jprb_builder.sv
rtl/jprb_serializer.sv
rtl/joypad_poll_response_builder_unit.sv
rtl/jprb_checker.sv
dv/tb_joypad_poll_response_builder_unit.sv
